// ----- design/btpc_pkg.sv -----
// Shared types and constants for the balanced-tree path/copath walker.
package btpc_pkg;

  // Width of the leaf-count register as seen on the configuration port
  localparam int CFG_W    = 17;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;
  localparam int STATUS_W = 2;

  // Register offsets, by index in bits [PADDR_W-1:2] of paddr
  localparam logic REG_LEAF_COUNT = 1'b0;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_STEP    = 2'd0,
    STATUS_OUTSIDE = 2'd1,
    STATUS_SINGLE  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_UP,
    BK_SIB,
    BK_EMIT
  } back_state_t;

endpackage

// ----- design/btpc_if.sv -----
// Channel interfaces: leaf requests in, path/copath results out.
interface btpc_in_if #(
  parameter int PW = 16
) ();
  logic          valid;
  logic          ready;
  logic [PW-1:0] leaf_position;

  modport source (output valid, output leaf_position, input ready);
  modport sink   (input valid, input leaf_position, output ready);
endinterface

interface btpc_out_if #(
  parameter int NW = 17
) ();
  logic                          valid;
  logic                          ready;
  logic [NW-1:0]                 path_node;
  logic [NW-1:0]                 copath_node;
  logic [btpc_pkg::STATUS_W-1:0] status;
  logic                          last;

  modport source (output valid, output path_node, output copath_node, output status,
                  output last, input ready);
  modport sink   (input valid, input path_node, input copath_node, input status,
                  input last, output ready);
endinterface

// ----- design/balanced_tree_path_copath_core.sv -----
// Top level of the balanced-tree direct path / copath walker.
//
// Usage: write leaf_count over the APB port (offset 0x0, bits [16:0]); a value of
// zero reads as one leaf, a value above 2^LOG_MAX_LEAVES is clamped to it.
// Send a leaf position on in_ch; the block returns one beat on out_ch per
// ancestor from that leaf up to the root: path_node, copath_node, status and
// last, with last set on the final beat of the item. A position outside the
// tree returns one beat with status "outside"; a one-leaf tree returns one
// beat with status "single". Node fields are zero on those beats.
// Flow: the front classifies a request in the cycle it is accepted and
// parks it in a two-entry command queue, so up to two requests wait while the
// walker is busy. The walker picks up a command, then per level probes the
// parent (once more for each missing ancestor skipped), probes the sibling
// when the sibling is on the right, and loads the output register.
// Reset: leaf_count returns to 1, the queue and output register empty.
// Stall: a beat holds in the output register until out_ch.ready; the walker
// then halts and the queue keeps accepting until full.
module balanced_tree_path_copath_core #(
  parameter int LOG_MAX_LEAVES = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [btpc_pkg::PADDR_W-1:0]   paddr,
  input  logic [btpc_pkg::PDATA_W-1:0]   pwdata,
  output logic [btpc_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  btpc_in_if.sink                        in_ch,
  btpc_out_if.source                     out_ch
);

  localparam int PW    = LOG_MAX_LEAVES;
  localparam int NW    = PW + 1;
  localparam int CMD_W = NW + btpc_pkg::STATUS_W;

  logic [btpc_pkg::CFG_W-1:0] leaf_count;  // as written, for read back
  logic [NW-1:0]              leaf_n;      // clamped leaf count
  logic                       cfg_wr;
  logic [31:0]                wr_val;
  logic [31:0]                cap;
  logic [31:0]                eff_val;
  logic [NW-1:0]              count;
  logic [NW-1:0]              root;

  logic                       q_push;
  logic [CMD_W-1:0]           q_din;
  logic                       q_full;
  logic                       q_pop;
  logic                       q_valid;
  logic [CMD_W-1:0]           q_dout;

  // APB register file: one register, writes complete in the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == btpc_pkg::REG_LEAF_COUNT);
  assign prdata = btpc_pkg::PDATA_W'(leaf_count);

  // Clamp the written value into 1 .. 2^LOG_MAX_LEAVES
  assign wr_val = 32'(pwdata[btpc_pkg::CFG_W-1:0]);
  assign cap    = 32'(1) << LOG_MAX_LEAVES;

  always_comb begin
    if (wr_val == '0) begin
      eff_val = 32'(1);
    end else if (wr_val > cap) begin
      eff_val = cap;
    end else begin
      eff_val = wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      leaf_count <= btpc_pkg::CFG_W'(1);
      leaf_n     <= NW'(1);
    end else if (cfg_wr) begin
      leaf_count <= pwdata[btpc_pkg::CFG_W-1:0];
      leaf_n     <= eff_val[NW-1:0];
    end
  end

  // Node count 2n-1 and root 2^d-1 (smear the bits of n-1 downward)
  assign count = NW'({leaf_n, 1'b0} - (NW + 1)'(1));

  always_comb begin
    root = leaf_n - NW'(1);
    for (int s = 1; s < NW; s = s * 2) begin
      root = root | (root >> s);
    end
  end

  btpc_front #(
    .PW    (PW),
    .NW    (NW),
    .CMD_W (CMD_W)
  ) u_front (
    .in_ch  (in_ch),
    .leaf_n (leaf_n),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_din)
  );

  btpc_queue #(
    .WIDTH (CMD_W),
    .DEPTH (2)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_dout)
  );

  btpc_back #(
    .NW    (NW),
    .CMD_W (CMD_W)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_dout),
    .q_pop   (q_pop),
    .count   (count),
    .root    (root),
    .out_ch  (out_ch)
  );

  // Error and single-leaf beats always close their item
  a_special_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && (out_ch.status != btpc_pkg::STATUS_STEP)) |-> out_ch.last)
    else $error("special-status beat without last");

  // Every walk beat names nodes that exist in the tree
  a_nodes_in_tree: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && (out_ch.status == btpc_pkg::STATUS_STEP)) |->
      ((out_ch.path_node < count) && (out_ch.copath_node < count)))
    else $error("walk beat names a node outside the tree");

  // The final walk beat is the root
  a_last_is_root: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.last && (out_ch.status == btpc_pkg::STATUS_STEP)) |->
      (out_ch.path_node == root))
    else $error("walk ended below the root");

  // The walker pops only a command that is there
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("command queue popped while empty");

endmodule

// ----- design/btpc_queue.sv -----
// Small FIFO of classified commands between front and back.
module btpc_queue #(
  parameter int WIDTH = 19,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] dout
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    fill;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign full  = (fill == CW'(DEPTH));
  assign valid = (fill != '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        fill <= fill + CW'(1);
      end else if (pop && !push) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule

// ----- design/btpc_front.sv -----
// Front end: accept leaf requests and classify them into walk commands.
module btpc_front #(
  parameter int PW    = 16,
  parameter int NW    = PW + 1,
  parameter int CMD_W = NW + btpc_pkg::STATUS_W
) (
  btpc_in_if.sink          in_ch,
  input  logic [NW-1:0]    leaf_n,
  input  logic             q_full,
  output logic             q_push,
  output logic [CMD_W-1:0] q_cmd
);

  btpc_pkg::status_t kind;
  logic [NW-1:0]     start_node;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;
  assign start_node  = {in_ch.leaf_position, 1'b0};

  always_comb begin
    if (NW'(in_ch.leaf_position) >= leaf_n) begin
      kind = btpc_pkg::STATUS_OUTSIDE;
    end else if (leaf_n == NW'(1)) begin
      kind = btpc_pkg::STATUS_SINGLE;
    end else begin
      kind = btpc_pkg::STATUS_STEP;
    end
  end

  assign q_cmd = {kind, start_node};

endmodule

// ----- design/btpc_back.sv -----
// Back end: climb from the start leaf to the root and emit one beat per level.
module btpc_back #(
  parameter int NW    = 17,
  parameter int CMD_W = NW + btpc_pkg::STATUS_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  logic [CMD_W-1:0] q_cmd,
  output logic             q_pop,
  input  logic [NW-1:0]    count,
  input  logic [NW-1:0]    root,
  btpc_out_if.source       out_ch
);

  localparam int LW = $clog2(NW + 1);

  btpc_pkg::back_state_t state, state_next;
  btpc_pkg::status_t     kind, kind_next;
  logic [NW-1:0]         cur, cur_next;
  logic [NW-1:0]         node, node_next;
  logic [NW-1:0]         sib, sib_next;
  logic [LW-1:0]         lvl, lvl_next;
  logic [LW-1:0]         slvl, slvl_next;

  logic                  ovalid;
  logic                  o_load;
  logic                  o_last;
  logic [NW-1:0]         opath;
  logic [NW-1:0]         ocopath;
  btpc_pkg::status_t     ostatus;
  logic                  olast;
  logic                  slot_free;

  function automatic logic [NW-1:0] bit_at(input logic [LW-1:0] k);
    bit_at = NW'(1) << k;
  endfunction

  // Set bit k, clear bit k+1: the parent candidate one level up
  function automatic logic [NW-1:0] up_step(input logic [NW-1:0] x,
                                            input logic [LW-1:0] k);
    logic [LW-1:0] k1;
    k1      = k + LW'(1);
    up_step = (x | bit_at(k)) & ~bit_at(k1);
  endfunction

  assign slot_free = !ovalid || out_ch.ready;
  assign o_last    = (kind != btpc_pkg::STATUS_STEP) || (node == root);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= btpc_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    kind <= kind_next;
    cur  <= cur_next;
    node <= node_next;
    sib  <= sib_next;
    lvl  <= lvl_next;
    slvl <= slvl_next;
  end

  always_comb begin
    state_next = state;
    kind_next  = kind;
    cur_next   = cur;
    node_next  = node;
    sib_next   = sib;
    lvl_next   = lvl;
    slvl_next  = slvl;
    q_pop      = 1'b0;
    o_load     = 1'b0;
    unique case (state)
      btpc_pkg::BK_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          kind_next = btpc_pkg::status_t'(q_cmd[CMD_W-1:NW]);
          if (btpc_pkg::status_t'(q_cmd[CMD_W-1:NW]) == btpc_pkg::STATUS_STEP) begin
            cur_next   = q_cmd[NW-1:0];
            node_next  = up_step(q_cmd[NW-1:0], '0);
            lvl_next   = LW'(1);
            state_next = btpc_pkg::BK_UP;
          end else begin
            node_next  = '0;
            sib_next   = '0;
            state_next = btpc_pkg::BK_EMIT;
          end
        end
      end
      btpc_pkg::BK_UP: begin
        if (node >= count) begin
          node_next = up_step(node, lvl);
          lvl_next  = lvl + LW'(1);
        end else if (cur < node) begin
          sib_next   = node + bit_at(lvl - LW'(1));
          slvl_next  = lvl - LW'(1);
          state_next = btpc_pkg::BK_SIB;
        end else begin
          sib_next   = node - bit_at(lvl - LW'(1));
          state_next = btpc_pkg::BK_EMIT;
        end
      end
      btpc_pkg::BK_SIB: begin
        if ((sib >= count) && (slvl != '0)) begin
          sib_next  = sib - bit_at(slvl - LW'(1));
          slvl_next = slvl - LW'(1);
        end else begin
          state_next = btpc_pkg::BK_EMIT;
        end
      end
      btpc_pkg::BK_EMIT: begin
        if (slot_free) begin
          o_load = 1'b1;
          if (o_last) begin
            state_next = btpc_pkg::BK_IDLE;
          end else begin
            cur_next   = node;
            node_next  = up_step(node, lvl);
            lvl_next   = lvl + LW'(1);
            state_next = btpc_pkg::BK_UP;
          end
        end
      end
      default: begin
        state_next = btpc_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (o_load) begin
      ovalid <= 1'b1;
    end else if (out_ch.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      opath   <= node;
      ocopath <= sib;
      ostatus <= kind;
      olast   <= o_last;
    end
  end

  assign out_ch.valid       = ovalid;
  assign out_ch.path_node   = opath;
  assign out_ch.copath_node = ocopath;
  assign out_ch.status      = ostatus;
  assign out_ch.last        = olast;

endmodule

// ----- test/tb_balanced_tree_path_copath_core.sv -----
// Testbench for the balanced-tree direct path / copath walker: stimulus, prediction and checks.
module tb_balanced_tree_path_copath_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LOG_LEAVES  = 16;
  localparam int MAX_LEAVES  = 1 << LOG_LEAVES;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;
  localparam logic [btpc_pkg::PADDR_W-1:0] LEAF_COUNT_ADDR = {btpc_pkg::REG_LEAF_COUNT, 2'b00};

  // One result beat as the output channel carries it
  typedef struct {
    logic [16:0]       path_node;
    logic [16:0]       copath_node;
    btpc_pkg::status_t status;
    logic              last;
  } path_beat_t;

  // Predicts the path/copath beats of every accepted leaf request and checks
  // each delivered beat against the oldest prediction.
  class path_scoreboard;
    logic [16:0] leaf_count_reg;
    path_beat_t  expected_beats[$];
    int          errors;
    int          leaves_taken;
    int          beats_checked;

    function new();
      leaf_count_reg = 17'd1;
      errors         = 0;
      leaves_taken   = 0;
      beats_checked  = 0;
    endfunction

    function void set_leaf_count(logic [16:0] value);
      leaf_count_reg = value;
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    // Clamp the register to 1 .. 2^LOG_LEAVES
    function longint unsigned effective_leaves();
      longint unsigned n;
      n = leaf_count_reg;
      if (n < 1) n = 1;
      if (n > MAX_LEAVES) n = MAX_LEAVES;
      return n;
    endfunction

    // Level of a node = count of trailing one bits
    function int unsigned level_of(longint unsigned x);
      int unsigned k;
      k = 0;
      while (x[0] && k < 62) begin
        k++;
        x = x >> 1;
      end
      return k;
    endfunction

    function longint unsigned climb(longint unsigned x);
      int unsigned k;
      longint unsigned v;
      k = level_of(x);
      v = x | (64'd1 << k);
      return v & ~(64'd1 << (k + 1));
    endfunction

    function longint unsigned left_of(longint unsigned p);
      int unsigned k;
      k = level_of(p);
      if (k == 0) return p;
      return p - (64'd1 << (k - 1));
    endfunction

    // Step right once, then left until the node exists
    function longint unsigned right_of(longint unsigned p, longint unsigned node_count);
      int unsigned k;
      int unsigned guard;
      longint unsigned r;
      k = level_of(p);
      guard = 0;
      if (k == 0) return p;
      r = p + (64'd1 << (k - 1));
      while (r >= node_count && level_of(r) > 0 && guard < 64) begin
        r = left_of(r);
        guard++;
      end
      return r;
    endfunction

    // Climb until the ancestor exists in the tree
    function longint unsigned parent_in_tree(longint unsigned x, longint unsigned node_count);
      int unsigned guard;
      longint unsigned p;
      guard = 0;
      p = climb(x);
      while (p >= node_count && guard < 64) begin
        p = climb(p);
        guard++;
      end
      return p;
    endfunction

    function void note_leaf(logic [15:0] leaf_position);
      longint unsigned n;
      longint unsigned pos;
      longint unsigned node_count;
      longint unsigned span;
      longint unsigned root;
      longint unsigned cur;
      longint unsigned p;
      longint unsigned sib;
      path_beat_t      beat;
      path_beat_t      walk[$];
      n          = effective_leaves();
      pos        = leaf_position;
      node_count = 2 * n - 1;
      leaves_taken++;
      if (pos >= n || n == 1) begin
        beat.path_node   = '0;
        beat.copath_node = '0;
        beat.status      = (pos >= n) ? btpc_pkg::STATUS_OUTSIDE : btpc_pkg::STATUS_SINGLE;
        beat.last        = 1'b1;
        expected_beats = {expected_beats, beat};
        return;
      end
      span = 1;
      while (span < n) span = span << 1;
      root = span - 1;
      cur  = 2 * pos;
      while (cur != root && walk.size() < LOG_LEAVES) begin
        p   = parent_in_tree(cur, node_count);
        sib = (cur < p) ? right_of(p, node_count) : left_of(p);
        beat.path_node   = p[16:0];
        beat.copath_node = sib[16:0];
        beat.status      = btpc_pkg::STATUS_STEP;
        beat.last        = (p == root);
        walk = {walk, beat};
        cur = p;
      end
      walk[walk.size() - 1].last = 1'b1;
      foreach (walk[i]) expected_beats = {expected_beats, walk[i]};
    endfunction

    function void check_beat(path_beat_t got);
      path_beat_t want;
      beats_checked++;
      if (expected_beats.size() == 0) begin
        $error("unexpected result beat: path_node %0d copath_node %0d status %0d last %0d",
               got.path_node, got.copath_node, got.status, got.last);
        errors++;
        return;
      end
      want = expected_beats.pop_front();
      if (got.path_node !== want.path_node) begin
        $error("path_node expected %0d actual %0d", want.path_node, got.path_node);
        errors++;
      end
      if (got.copath_node !== want.copath_node) begin
        $error("copath_node expected %0d actual %0d", want.copath_node, got.copath_node);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status expected %0d actual %0d", want.status, got.status);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last expected %0d actual %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [btpc_pkg::PADDR_W-1:0]  paddr;
  logic [btpc_pkg::PDATA_W-1:0]  pwdata;
  logic [btpc_pkg::PDATA_W-1:0]  prdata;
  logic                          pready;

  btpc_in_if  #(.PW(16)) in_ch ();
  btpc_out_if #(.NW(17)) out_ch ();

  balanced_tree_path_copath_core #(
    .LOG_MAX_LEAVES(LOG_LEAVES)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

  path_scoreboard sb = new();

  int  cycle_count = 0;
  int  phases_run  = 0;
  // Set by the stimulus to ask the receiver for one long hold-off
  bit  hold_req    = 1'b0;
  bit  hold_taken  = 1'b0;

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Watchdog: end the run if the block stops making progress
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL balanced_tree_path_copath_core");
      $finish;
    end
  end

  // Note each accepted leaf request; values are the ones present at the edge
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) sb.note_leaf(in_ch.leaf_position);
  end

  // Check each accepted result beat
  always @(posedge clk) begin
    path_beat_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.path_node   = out_ch.path_node;
      got.copath_node = out_ch.copath_node;
      got.status      = btpc_pkg::status_t'(out_ch.status);
      got.last        = out_ch.last;
      sb.check_beat(got);
    end
  end

  // Receiver: cycle through stall modes of random length; once on request,
  // hold ready low for a long stretch so the queue fills and the input stalls.
  initial begin : rx_stall
    int mode;
    int span_left;
    int hold_left;
    int tick;
    mode      = 0;
    span_left = 0;
    hold_left = 0;
    tick      = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (span_left == 0) begin
        mode      = $urandom_range(0, 3);
        span_left = $urandom_range(20, 200);
      end
      span_left--;
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ch.ready <= 1'b1;                              // no stalls
          1: out_ch.ready <= ($urandom_range(0, 99) < 70);      // light random stalls
          2: out_ch.ready <= ($urandom_range(0, 99) < 25);      // heavy random stalls
          default: out_ch.ready <= ((tick % 5) < 2);            // fixed rhythm
        endcase
      end
      @(posedge clk);
    end
  end

  // Drive one leaf request and hold it until the block takes it
  task automatic offer_leaf(input logic [15:0] pos);
    in_ch.valid         <= 1'b1;
    in_ch.leaf_position <= pos;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Drop valid and wait out the requested gap
  task automatic idle_sender(input int cycles);
    in_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Wait until every predicted beat has come back, then let the block settle
  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write the leaf count: setup cycle, then access cycle
  task automatic write_leaf_count(input logic [16:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LEAF_COUNT_ADDR;
    pwdata  <= {{(btpc_pkg::PDATA_W-17){1'b0}}, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_leaf_count(value);
    phases_run++;
  endtask

  // Mostly in-tree leaves, some edges of the tree, some arbitrary positions
  function automatic logic [15:0] pick_leaf(longint unsigned n);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 12) return 16'($urandom());
    if (roll < 17) return 16'd0;
    if (roll < 22) return 16'(n - 1);
    if (roll < 25 && n < MAX_LEAVES) return 16'(n);
    return 16'($urandom_range(0, int'(n - 1)));
  endfunction

  // Offer random leaves in bursts with random gaps; some bursts run long
  task automatic random_leaves(input int count);
    int burst;
    int sent;
    sent = 0;
    while (sent < count) begin
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      while (burst > 0 && sent < count) begin
        offer_leaf(pick_leaf(sb.effective_leaves()));
        burst--;
        sent++;
      end
      idle_sender($urandom_range(1, 15));
    end
  endtask

  task automatic directed_leaves(input logic [15:0] list[$]);
    foreach (list[i]) offer_leaf(list[i]);
    idle_sender(1);
  endtask

  initial begin : stimulus
    logic [16:0] phase_counts[$];
    rst                 <= 1'b1;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.leaf_position <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset leaf count of one gives the single-leaf and outside cases
    directed_leaves('{16'd0, 16'd1, 16'hFFFF});
    drain();
    // Full tree: extreme leaves and alternating bit patterns
    write_leaf_count(17'd65536);
    directed_leaves('{16'd0, 16'hFFFF, 16'h8000, 16'h5555, 16'hAAAA});
    drain();
    // Ragged tree: missing ancestors and right siblings to skip, one past the end
    write_leaf_count(17'd5);
    directed_leaves('{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5});
    drain();
    write_leaf_count(17'd3);
    directed_leaves('{16'd1, 16'd2, 16'd3});
    drain();
    // Zero leaf count reads as one leaf
    write_leaf_count(17'd0);
    directed_leaves('{16'd0, 16'd1});
    drain();
    // Oversized leaf count clamps to the full tree
    write_leaf_count(17'h1FFFF);
    directed_leaves('{16'hFFFF, 16'd0});
    drain();

    // Random phases over a spread of tree sizes, extremes included
    phase_counts = '{17'd2, 17'd3, 17'd6, 17'd100, 17'd1000, 17'd65535, 17'd65536,
                     17'd65537, 17'($urandom_range(1, 131071)), 17'd40000, 17'd17};
    foreach (phase_counts[i]) begin
      write_leaf_count(phase_counts[i]);
      // Ask for the long receiver hold-off during the full-tree phase
      if (phase_counts[i] == 17'd65536) hold_req = 1'b1;
      random_leaves(45);
      drain();
    end

    repeat (100) @(posedge clk);
    $display("Ran %0d leaf requests over %0d tree sizes, checked %0d result beats",
             sb.leaves_taken, phases_run + 1, sb.beats_checked);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS balanced_tree_path_copath_core");
    end else begin
      if (sb.pending() != 0) $error("%0d predicted beats never arrived", sb.pending());
      $display("FAIL balanced_tree_path_copath_core");
    end
    $finish;
  end

endmodule
